// ===== design/rm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_pkg
// Shared sizes and types of the running median block.
// ----------------------------------------------------------------------------
package rm_pkg;

	localparam int CAPACITY  = 1024;
	localparam int SAMPLE_W  = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int MED_W     = SAMPLE_W + 1;
	localparam int GROUP     = 32;
	localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MED_W-1:0]    median_t;
	typedef logic        [CNT_W-1:0]    count_t;
	typedef logic        [IDX_W-1:0]    index_t;

endpackage

// ===== design/rm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_in_if
// Sample request channel: valid/ready with sample and clear flag.
// ----------------------------------------------------------------------------
interface rm_in_if;
	import rm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    clear;

	modport source (output valid, output sample, output clear, input ready);
	modport sink   (input valid, input sample, input clear, output ready);
endinterface

// ===== design/rm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_out_if
// Result request channel: valid/ready with doubled median, count and full flag.
// ----------------------------------------------------------------------------
interface rm_out_if;
	import rm_pkg::*;

	logic    valid;
	logic    ready;
	median_t median_doubled;
	count_t  held_count;
	logic    full_res;

	modport source (output valid, output median_doubled, output held_count,
		output full_res, input ready);
	modport sink   (input valid, input median_doubled, input held_count,
		input full_res, output ready);
endinterface

// ===== design/rm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_cell
// One slot of the sorted chain. On an insert it keeps its value, takes the
// new sample, or takes its left neighbor's value, so the chain stays sorted.
// ----------------------------------------------------------------------------
module rm_cell (
	input  logic             clk,
	input  logic             wr,
	input  rm_pkg::count_t   idx,
	input  rm_pkg::count_t   fill,
	input  rm_pkg::sample_t  x,
	input  rm_pkg::sample_t  left_val,
	input  logic             left_take,
	output rm_pkg::sample_t  val,
	output logic             take
);
	import rm_pkg::*;

	sample_t val_q;
	logic    held;

	// slot moves when empty or holding a value above the new sample
	assign held = idx < fill;
	assign take = !held || (val_q > x);
	assign val  = val_q;

	// shift right or load the new sample
	always_ff @(posedge clk) begin
		if (wr && take) begin
			val_q <= left_take ? left_val : x;
		end
	end
endmodule

// ===== design/rm_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_sel
// First level of the median pick: per group of cells, the masked OR of the
// lower and upper middle entries, registered.
// ----------------------------------------------------------------------------
module rm_sel (
	input  logic            clk,
	input  logic            en,
	input  rm_pkg::sample_t cells [rm_pkg::CAPACITY],
	input  rm_pkg::count_t  fill,
	output rm_pkg::sample_t lo,
	output rm_pkg::sample_t hi
);
	import rm_pkg::*;

	index_t  idx_hi;
	index_t  idx_lo;
	sample_t grp_lo_d [NGROUPS];
	sample_t grp_hi_d [NGROUPS];
	sample_t grp_lo_s2 [NGROUPS];
	sample_t grp_hi_s2 [NGROUPS];

	// middle positions: odd count uses one entry twice
	assign idx_hi = index_t'(fill >> 1);
	assign idx_lo = fill[0] ? idx_hi : index_t'(idx_hi - index_t'(1));

	// masked OR within each group
	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			grp_lo_d[g] = '0;
			grp_hi_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					if (index_t'(g * GROUP + k) == idx_lo) begin
						grp_lo_d[g] = grp_lo_d[g] | cells[g * GROUP + k];
					end
					if (index_t'(g * GROUP + k) == idx_hi) begin
						grp_hi_d[g] = grp_hi_d[g] | cells[g * GROUP + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_lo_s2 <= grp_lo_d;
			grp_hi_s2 <= grp_hi_d;
		end
	end

	// OR across groups
	always_comb begin
		lo = '0;
		hi = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			lo = lo | grp_lo_s2[g];
			hi = hi | grp_hi_s2[g];
		end
	end
endmodule

// ===== design/running_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median
// Running median over a bounded sorted store, kept in a chain of cells.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  samples   | in  | sample, clear
//  medians   | out | median_doubled, held_count, full_res
//
// One sample is taken every cycle while the result side is not stalled; each
// request yields one result after the insert in the cell chain, the group pick
// and the final pick, each registered. An insert updates all cells together.
// Reset clears the fill count and the pipeline valids; the cells need none.
// A stalled result stalls the whole pipeline, and sample ready drops with it.
module running_median (
	input  logic     clk,
	input  logic     arst_n,
	rm_in_if.sink    samples,
	rm_out_if.source medians
);
	import rm_pkg::*;

	logic    en;
	logic    accept;
	count_t  fill_eff;
	logic    is_full;
	logic    wr;
	count_t  fill_q;
	sample_t cells [CAPACITY];
	logic    takes [CAPACITY];
	sample_t lo;
	sample_t hi;

	logic    v_s1;
	logic    full_s1;
	logic    v_s2;
	logic    full_s2;
	count_t  cnt_s2;
	logic    out_valid_q;
	median_t median_q;
	count_t  count_q;
	logic    full_q;

	// whole pipeline moves together
	assign en     = !out_valid_q || medians.ready;
	assign accept = samples.valid && en;
	assign samples.ready = en;

	// fill count seen by this request, after an optional clear
	assign fill_eff = samples.clear ? count_t'(0) : fill_q;
	assign is_full  = fill_eff == count_t'(CAPACITY);
	assign wr       = accept && !is_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= is_full ? fill_eff : count_t'(fill_eff + count_t'(1));
		end
	end

	// sorted chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rm_cell u_cell (
			.clk       (clk),
			.wr        (wr),
			.idx       (count_t'(i)),
			.fill      (fill_eff),
			.x         (samples.sample),
			.left_val  ((i == 0) ? samples.sample : cells[(i == 0) ? 0 : i - 1]),
			.left_take ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i - 1]),
			.val       (cells[i]),
			.take      (takes[i])
		);
	end

	// median pick from the updated chain
	rm_sel u_sel (
		.clk   (clk),
		.en    (en),
		.cells (cells),
		.fill  (fill_q),
		.lo    (lo),
		.hi    (hi)
	);

	// pipeline control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1  <= is_full;
			full_s2  <= full_s1;
			cnt_s2   <= fill_q;
			median_q <= median_t'(lo) + median_t'(hi);
			count_q  <= cnt_s2;
			full_q   <= full_s2;
		end
	end

	assign medians.valid          = out_valid_q;
	assign medians.median_doubled = median_q;
	assign medians.held_count     = count_q;
	assign medians.full_res       = full_q;
endmodule

// ===== tb/sv/tb_running_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_median
// Self-checking bench for the running median block. A scoreboard class keeps
// its own sorted copy of the held samples and works out the doubled median,
// the count and the full flag for every sample the block accepts. Plain tasks
// drive the stimulus: a directed pass over the extreme values, clears and
// repeated samples, then random runs between clears, including one that
// fills the store and pushes samples past it. Random gaps and stalls fall on
// both sides, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_running_median;
	import rm_pkg::*;

	localparam int NUM_RANDOM  = 1780;
	localparam int FILL_AT     = 300;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN       = 16;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		median_t med;
		count_t  cnt;
		logic    full;
	} median_rec_t;

	// keeps a sorted copy of the held samples and checks the results in order
	class median_scoreboard;
		sample_t     held[CAPACITY];
		int          fill;
		median_rec_t expected[$];
		int          errors;
		int          n_in;
		int          n_out;
		int          n_clear;
		int          n_dropped;
		int          peak_fill;

		function new();
			fill      = 0;
			errors    = 0;
			n_in      = 0;
			n_out     = 0;
			n_clear   = 0;
			n_dropped = 0;
			peak_fill = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH %0d: %s", $realtime, errors, msg);
		endtask

		// predict the result of one accepted sample
		function void note_sample(sample_t s, logic clr);
			median_rec_t rec;
			int          pos;
			int          half;
			int          twice;
			n_in++;
			if (clr) begin
				fill = 0;
				n_clear++;
			end
			rec.full = (fill >= CAPACITY);
			if (rec.full) begin
				n_dropped++;
			end else begin
				// insert after any equal samples
				pos = fill;
				while (pos > 0 && held[pos-1] > s) begin
					held[pos] = held[pos-1];
					pos--;
				end
				held[pos] = s;
				fill++;
			end
			if (fill > peak_fill)
				peak_fill = fill;
			half = fill / 2;
			if (fill == 0)
				twice = 0;
			else if (fill % 2)
				twice = 2 * int'(held[half]);
			else
				twice = int'(held[half-1]) + int'(held[half]);
			rec.med = median_t'(twice);
			rec.cnt = count_t'(fill);
			expected.push_back(rec);
		endfunction

		// compare one accepted result with the oldest prediction
		task check_result(median_t med, count_t cnt, logic full);
			median_rec_t want;
			n_out++;
			if (expected.size() == 0) begin
				report($sformatf("result %0d with none expected: median %0d count %0d full %0b",
					n_out, med, cnt, full));
				return;
			end
			want = expected.pop_front();
			if (med !== want.med)
				report($sformatf("result %0d median_doubled %0d, expected %0d",
					n_out, med, want.med));
			if (cnt !== want.cnt)
				report($sformatf("result %0d held_count %0d, expected %0d",
					n_out, cnt, want.cnt));
			if (full !== want.full)
				report($sformatf("result %0d full_res %0b, expected %0b",
					n_out, full, want.full));
		endtask
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   no_gaps = 1'b0;
	int   idle_cycles = 0;

	median_scoreboard sb = new();

	rm_in_if  samples_ch ();
	rm_out_if medians_ch ();

	running_median DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.medians (medians_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap before a request: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// sample value: full range, a narrow band for repeats, or the extremes
	function automatic sample_t pick_sample(int mode);
		int r;
		case (mode)
		0: begin
			return sample_t'($urandom);
		end
		1: begin
			return sample_t'($urandom_range(0, 8) - 4);
		end
		default: begin
			r = $urandom_range(0, 6);
			case (r)
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return 16'shFFFF;
			3: return 16'sh0000;
			4: return 16'sh0001;
			5: return 16'sh7FFE;
			default: return 16'sh7FFF;
			endcase
		end
		endcase
	endfunction

	// offer one sample request and wait until it is taken
	task automatic send_sample(input sample_t s, input logic clr);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			samples_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= s;
		samples_ch.clear  <= clr;
		do
			@(posedge clk);
		while (samples_ch.ready !== 1'b1);
		sb.note_sample(s, clr);
	endtask

	// result side ready pattern, with one long hold-off
	initial begin : result_sink
		int  r;
		int  span;
		bit  held_off;
		held_off = 1'b0;
		medians_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sb.n_in >= HOLD_AT) begin
				held_off = 1'b1;
				medians_ch.ready <= 1'b0;
				span = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					medians_ch.ready <= 1'b1;
					span = 1;
				end else if (r < 90) begin
					medians_ch.ready <= 1'b0;
					span = $urandom_range(1, 3);
				end else if (r < 95) begin
					medians_ch.ready <= 1'b0;
					span = $urandom_range(8, 40);
				end else begin
					medians_ch.ready <= 1'b1;
					span = $urandom_range(20, 60);
				end
			end
			repeat (span - 1) @(negedge clk);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && medians_ch.valid === 1'b1 && medians_ch.ready === 1'b1)
			sb.check_result(medians_ch.median_doubled, medians_ch.held_count,
				medians_ch.full_res);
	end

	// watchdog on cycles with no request taken on either side
	always @(posedge clk) begin
		if (!arst_n || (samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1) ||
			(medians_ch.valid === 1'b1 && medians_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] timeout: nothing taken for %0d cycles, %0d results pending",
				$realtime, STALL_LIMIT, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus
	initial begin : sample_source
		int  n;
		int  run_len;
		int  mode;
		bit  filled;
		samples_ch.valid  = 1'b0;
		samples_ch.sample = '0;
		samples_ch.clear  = 1'b0;
		filled = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, clears, repeated values, both ends of the median
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0005, 1'b1);
		send_sample(16'sh0005, 1'b0);
		send_sample(16'sh0005, 1'b0);
		send_sample(16'sh0005, 1'b0);
		send_sample(16'sh5555, 1'b1);
		send_sample(16'shAAAA, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh7FFF, 1'b0);

		// random runs, each opened by a clear; one run fills the store and overflows
		n = 0;
		while (n < NUM_RANDOM) begin
			if (!filled && n >= FILL_AT) begin
				filled  = 1'b1;
				run_len = CAPACITY + $urandom_range(8, 24);
			end else begin
				run_len = $urandom_range(1, 40);
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
			for (int k = 0; k < run_len; k++) begin
				if (filled && run_len > CAPACITY && $urandom_range(0, 4) == 0)
					send_sample(pick_sample($urandom_range(0, 2)), k == 0);
				else
					send_sample(pick_sample(mode), k == 0);
				n++;
			end
		end
		no_gaps = 1'b0;
		@(negedge clk);
		samples_ch.valid <= 1'b0;

		// drain
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d samples to %0d results: %0d clears, %0d dropped while full",
			sb.n_in, sb.n_out, sb.n_clear, sb.n_dropped);
		$display("Peak fill %0d of %0d, one result-side hold-off of %0d cycles",
			sb.peak_fill, CAPACITY, HOLD_CYCLES);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rm_pkg.sv
design/rm_in_if.sv
design/rm_out_if.sv
design/rm_cell.sv
design/rm_sel.sv
design/running_median.sv
tb/sv/tb_running_median.sv
